@@ sv/ctf_pkg.sv @@
package ctf_pkg;

	// Datapath sizing
	localparam int CORDIC_STEPS    = 16;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int GUARD_BITS      = 14;
	localparam int STEP_W          = $clog2(CORDIC_STEPS);
	localparam int CW              = 40;   // CORDIC x/y width
	localparam int ZW              = 44;   // CORDIC angle accumulator, Q32 degrees
	localparam int AW              = 28;   // rounded angle width
	localparam int TAB_FRAC        = 40;
	localparam int ANGLE_LIM       = 180 << ANGLE_FRAC_BITS;

	localparam logic [31:0] KINV_Q32   = 32'd2608131496;
	localparam logic [63:0] R2D_Q16    = 64'd3754936;
	localparam logic [16:0] UNITY_GAIN = 17'd65536;

	// Configuration register indexes
	localparam int CFG_W = 3;
	localparam logic [CFG_W-1:0] CFG_AX_OFS = 3'd0;
	localparam logic [CFG_W-1:0] CFG_AY_OFS = 3'd1;
	localparam logic [CFG_W-1:0] CFG_AZ_OFS = 3'd2;
	localparam logic [CFG_W-1:0] CFG_GX_OFS = 3'd3;
	localparam logic [CFG_W-1:0] CFG_GY_OFS = 3'd4;
	localparam logic [CFG_W-1:0] CFG_GZ_OFS = 3'd5;
	localparam logic [CFG_W-1:0] CFG_GAIN   = 3'd6;
	localparam logic [CFG_W-1:0] CFG_SCALE  = 3'd7;

	typedef struct packed {
		logic                 start;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} cordic_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [CW-1:0] xn;
		logic signed [AW-1:0] angle;
	} cordic_rsp_t;

	typedef logic [ZW-1:0] atan_tab_t [CORDIC_STEPS];

	// atan(2^-i) in Q32 degrees: truncated Taylor series in Q40 radians, scaled
	function automatic atan_tab_t build_atan_tab();
		atan_tab_t   tab;
		logic [63:0] sum;
		logic [63:0] term;
		int unsigned e;
		for (int unsigned i = 0; i < CORDIC_STEPS; i++) begin
			sum = '0;
			for (int unsigned k = 0; k < 64; k++) begin
				e = i * (2 * k + 1);
				if (e <= TAB_FRAC) begin
					term = (64'd1 << (TAB_FRAC - e)) / 64'(2 * k + 1);
					if (k % 2 == 1) sum = sum - term;
					else sum = sum + term;
				end
			end
			if (i == 0) tab[i] = ZW'(64'd45 << 32);
			else tab[i] = ZW'((sum * R2D_Q16) >> 24);
		end
		return tab;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan_tab();

endpackage

@@ sv/ctf_mul.sv @@
module ctf_mul (
	input  logic        clk,
	input  logic [32:0] a,
	input  logic [31:0] b,
	output logic [64:0] p_q
);
	// Registered unsigned product, shared by every multiply step
	always_ff @(posedge clk) begin
		p_q <= 65'(a) * 65'(b);
	end

endmodule

@@ sv/ctf_cordic.sv @@
module ctf_cordic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctf_pkg::cordic_req_t req,
	output ctf_pkg::cordic_rsp_t rsp
);
	import ctf_pkg::*;

	localparam logic signed [ZW-1:0] Z180 = ZW'(64'd180 << 32);
	localparam logic signed [ZW-1:0] ZRND = ZW'(64'd1 << (31 - ANGLE_FRAC_BITS));

	logic signed [CW-1:0] x_q, y_q, dx, dy;
	logic signed [ZW-1:0] z_q, tab, z_rnd;
	logic [STEP_W-1:0]    i_q;
	logic                 busy_q, done_q, zero_q;

	assign dx    = y_q >>> i_q;
	assign dy    = x_q >>> i_q;
	assign tab   = signed'(ATAN_TAB[i_q]);
	assign z_rnd = (z_q + ZRND) >>> (32 - ANGLE_FRAC_BITS);

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Fold left half plane on load, then rotate towards y = 0
	always_ff @(posedge clk) begin
		if (req.start) begin
			zero_q <= (req.x == '0) && (req.y == '0);
			if (req.x < 0) begin
				x_q <= -req.x;
				y_q <= -req.y;
				z_q <= (req.y >= 0) ? Z180 : -Z180;
			end else begin
				x_q <= req.x;
				y_q <= req.y;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - tab;
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.xn    = x_q;
	assign rsp.angle = zero_q ? '0 : z_rnd[AW-1:0];

endmodule

@@ sv/imu_complementary_tilt_filter.sv @@
// Channel  | Dir | Signals                      | Payload
// s_axis   | in  | tvalid tready tdata[127:0]   | one IMU sample
// m_axis   | out | tvalid tready tdata[119:0]   | fused angles, corrected axes
// cfg      | in  | cfg_we cfg_addr cfg_wdata    | offsets, blend gain, gyro scale
//
// A sample runs from transfer to result valid through three passes of the one
// iterative CORDIC unit (pitch, magnitude, roll) and sixteen filter steps, F1 to
// F8 for each axis, that use the shared multiplier for the two filter updates.
// s_axis_tready is low from transfer until the result is taken; a stalled
// result holds. arst_n clears angles and timestamp history and resets the
// configuration registers to their defaults.
module imu_complementary_tilt_filter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ctf_pkg::CFG_W-1:0] cfg_addr,
	input  logic [31:0]               cfg_wdata,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, timestamp_us
	input  logic [127:0]              s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// pitch_angle, roll_angle, accel_x_corrected, accel_y_corrected,
	// accel_z_corrected, gyro_z_corrected, 2 zero bits
	output logic [119:0]              m_axis_tdata
);
	import ctf_pkg::*;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_PIT   = 5'd1;
	localparam logic [4:0] ST_PIT_W = 5'd2;
	localparam logic [4:0] ST_MAG   = 5'd3;
	localparam logic [4:0] ST_MAG_W = 5'd4;
	localparam logic [4:0] ST_MAG_M = 5'd5;
	localparam logic [4:0] ST_ROL   = 5'd6;
	localparam logic [4:0] ST_ROL_W = 5'd7;
	localparam logic [4:0] ST_F1    = 5'd8;
	localparam logic [4:0] ST_F2    = 5'd9;
	localparam logic [4:0] ST_F3    = 5'd10;
	localparam logic [4:0] ST_F4    = 5'd11;
	localparam logic [4:0] ST_F5    = 5'd12;
	localparam logic [4:0] ST_F6    = 5'd13;
	localparam logic [4:0] ST_F7    = 5'd14;
	localparam logic [4:0] ST_F8    = 5'd15;
	localparam logic [4:0] ST_OUT   = 5'd16;

	localparam logic signed [50:0] GCLAMP = 51'sd1 <<< 40;
	localparam logic signed [59:0] LIM    = signed'(60'(ANGLE_LIM));

	logic [4:0] state_q;

	logic signed [15:0] ax_ofs_q, ay_ofs_q, az_ofs_q, gx_ofs_q, gy_ofs_q, gz_ofs_q;
	logic [16:0]        gain_q;
	logic [31:0]        scale_q;

	logic signed [16:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic [31:0]        dt_q, last_q;
	logic               seen_q, axis_q;
	logic signed [31:0] pitch_q, roll_q;
	logic signed [AW-1:0] acc_pitch_q, acc_roll_q;
	logic [31:0]        magu_q, p_lo_q;
	logic [47:0]        t1_q;
	logic [40:0]        gm_q;
	logic               sg_q;
	logic [57:0]        ag_q, lo_q;

	cordic_req_t cq;
	cordic_rsp_t cr;
	logic [32:0] mul_a;
	logic [31:0] mul_b;
	logic [64:0] prod_q;

	logic               in_xfer;
	logic [16:0]        gain_eff;
	logic signed [16:0] rate, ax_abs;
	logic signed [31:0] prev;
	logic signed [AW-1:0] acc;
	logic [AW-1:0]      acc_mag;
	logic [15:0]        rate_mag;
	logic [49:0]        inc;
	logic signed [50:0] g, g_cl, inc_s;
	logic [40:0]        gm;
	logic signed [59:0] tg, ta, ssum, r60, r_cl, ag_s, ba_s;
	logic [32:0]        xn_pos;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign gain_eff = (gain_q > UNITY_GAIN) ? UNITY_GAIN : gain_q;
	assign rate     = axis_q ? gx_q : gy_q;
	assign prev     = axis_q ? roll_q : pitch_q;
	assign acc      = axis_q ? acc_roll_q : acc_pitch_q;
	assign acc_mag  = acc[AW-1] ? AW'(-acc) : AW'(acc);
	assign rate_mag = rate[16] ? 16'(-rate) : rate[15:0];
	assign ax_abs   = ax_q[16] ? -ax_q : ax_q;
	assign xn_pos   = cr.xn[CW-1] ? '0 : cr.xn[32:0];

	ctf_cordic u_cordic (.clk(clk), .arst_n(arst_n), .req(cq), .rsp(cr));
	ctf_mul    u_mul    (.clk(clk), .a(mul_a), .b(mul_b), .p_q(prod_q));

	// Operand selection for the CORDIC unit
	always_comb begin
		cq = '0;
		unique case (state_q)
			ST_PIT: begin
				cq.start = 1'b1;
				cq.x = CW'(az_q) <<< GUARD_BITS;
				cq.y = -(CW'(ax_q) <<< GUARD_BITS);
			end
			ST_MAG: begin
				cq.start = 1'b1;
				cq.x = CW'(ax_abs) <<< GUARD_BITS;
				cq.y = CW'(az_q) <<< GUARD_BITS;
			end
			ST_ROL: begin
				cq.start = 1'b1;
				cq.x = signed'(CW'(magu_q));
				cq.y = CW'(ay_q) <<< GUARD_BITS;
			end
			default: cq = '0;
		endcase
	end

	// Operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MAG_W: begin mul_a = xn_pos;                 mul_b = KINV_Q32; end
			ST_F1:    begin mul_a = 33'(rate_mag);          mul_b = dt_q; end
			ST_F2:    begin mul_a = 33'(prod_q[47:32]);     mul_b = scale_q; end
			ST_F3:    begin mul_a = 33'(p_lo_q);            mul_b = scale_q; end
			ST_F5:    begin mul_a = 33'(gain_eff);          mul_b = gm_q[31:0]; end
			ST_F6:    begin mul_a = 33'(gain_eff);          mul_b = 32'(gm_q[40:32]); end
			ST_F7:    begin mul_a = 33'(UNITY_GAIN - gain_eff); mul_b = 32'(acc_mag); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// Gyro path: previous angle plus increment, clamped
	always_comb begin
		inc   = 50'(t1_q) + 50'(prod_q[63:32]);
		inc_s = signed'({1'b0, inc});
		g     = rate[16] ? (51'(prev) - inc_s) : (51'(prev) + inc_s);
		if (g > GCLAMP) g_cl = GCLAMP;
		else if (g < -GCLAMP) g_cl = -GCLAMP;
		else g_cl = g;
		gm = g_cl[50] ? 41'(-g_cl) : g_cl[40:0];
	end

	// Blend with the accelerometer angle, round and saturate
	always_comb begin
		ag_s = signed'(60'(ag_q));
		ba_s = signed'(60'(prod_q[43:0]));
		tg   = sg_q ? -ag_s : ag_s;
		ta   = acc[AW-1] ? -ba_s : ba_s;
		ssum = tg + ta + 60'sd32768;
		r60  = ssum >>> 16;
		if (r60 > LIM) r_cl = LIM;
		else if (r60 < -LIM) r_cl = -LIM;
		else r_cl = r60;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_ofs_q <= '0;
			ay_ofs_q <= '0;
			az_ofs_q <= '0;
			gx_ofs_q <= '0;
			gy_ofs_q <= '0;
			gz_ofs_q <= '0;
			gain_q   <= 17'd64225;
			scale_q  <= 32'd4294967;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_AX_OFS: ax_ofs_q <= signed'(cfg_wdata[15:0]);
				CFG_AY_OFS: ay_ofs_q <= signed'(cfg_wdata[15:0]);
				CFG_AZ_OFS: az_ofs_q <= signed'(cfg_wdata[15:0]);
				CFG_GX_OFS: gx_ofs_q <= signed'(cfg_wdata[15:0]);
				CFG_GY_OFS: gy_ofs_q <= signed'(cfg_wdata[15:0]);
				CFG_GZ_OFS: gz_ofs_q <= signed'(cfg_wdata[15:0]);
				CFG_GAIN:   gain_q   <= cfg_wdata[16:0];
				CFG_SCALE:  scale_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q  <= 1'b0;
			last_q  <= '0;
			pitch_q <= '0;
			roll_q  <= '0;
			axis_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_xfer) begin
					seen_q  <= 1'b1;
					last_q  <= s_axis_tdata[127:96];
					state_q <= ST_PIT;
				end
				ST_PIT:   state_q <= ST_PIT_W;
				ST_PIT_W: if (cr.done) state_q <= ST_MAG;
				ST_MAG:   state_q <= ST_MAG_W;
				ST_MAG_W: if (cr.done) state_q <= ST_MAG_M;
				ST_MAG_M: state_q <= ST_ROL;
				ST_ROL:   state_q <= ST_ROL_W;
				ST_ROL_W: if (cr.done) begin
					axis_q  <= 1'b0;
					state_q <= ST_F1;
				end
				ST_F1: state_q <= ST_F2;
				ST_F2: state_q <= ST_F3;
				ST_F3: state_q <= ST_F4;
				ST_F4: state_q <= ST_F5;
				ST_F5: state_q <= ST_F6;
				ST_F6: state_q <= ST_F7;
				ST_F7: state_q <= ST_F8;
				ST_F8: begin
					if (axis_q) begin
						roll_q  <= r_cl[31:0];
						state_q <= ST_OUT;
					end else begin
						pitch_q <= r_cl[31:0];
						axis_q  <= 1'b1;
						state_q <= ST_F1;
					end
				end
				ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Sample capture and intermediate results
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_xfer) begin
			ax_q <= 17'(signed'(s_axis_tdata[15:0]))  - 17'(ax_ofs_q);
			ay_q <= 17'(signed'(s_axis_tdata[31:16])) - 17'(ay_ofs_q);
			az_q <= 17'(signed'(s_axis_tdata[47:32])) - 17'(az_ofs_q);
			gx_q <= 17'(signed'(s_axis_tdata[63:48])) - 17'(gx_ofs_q);
			gy_q <= 17'(signed'(s_axis_tdata[79:64])) - 17'(gy_ofs_q);
			gz_q <= 17'(signed'(s_axis_tdata[95:80])) - 17'(gz_ofs_q);
			dt_q <= seen_q ? (s_axis_tdata[127:96] - last_q) : '0;
		end
		if (state_q == ST_PIT_W && cr.done) acc_pitch_q <= cr.angle;
		if (state_q == ST_MAG_M) magu_q <= prod_q[63:32];
		if (state_q == ST_ROL_W && cr.done) acc_roll_q <= cr.angle;
		if (state_q == ST_F2) p_lo_q <= prod_q[31:0];
		if (state_q == ST_F3) t1_q <= prod_q[47:0];
		if (state_q == ST_F4) begin
			gm_q <= gm;
			sg_q <= g_cl[50];
		end
		if (state_q == ST_F6) lo_q <= 58'(prod_q[48:0]);
		if (state_q == ST_F7) ag_q <= lo_q + (58'(prod_q[25:0]) << 32);
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {2'b00, gz_q, az_q, ay_q, ax_q, roll_q[24:0], pitch_q[24:0]};

endmodule

@@ sv/ctf_checker.sv @@
module ctf_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [119:0]              m_axis_tdata
);
	// One sample in flight: a transfer closes the input side
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready after sample transfer");

	// Never open for input while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while result pending");

	// Stalled result stays valid and holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// Fused angles stay within plus or minus 180 degrees
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[24:0]) <= 25'sd11796480)
			&& ($signed(m_axis_tdata[24:0]) >= -25'sd11796480)
			&& ($signed(m_axis_tdata[49:25]) <= 25'sd11796480)
			&& ($signed(m_axis_tdata[49:25]) >= -25'sd11796480))
		else $error("fused angle out of range");

endmodule

bind imu_complementary_tilt_filter ctf_checker u_ctf_checker (.*);
